// File: rtl/assert_macros.svh
// Assertion macros shared by the queue and back-end RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a property holds at every rising clock edge outside reset.
`define SPP_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion violated");

// Checks that a condition implies a consequence in the same cycle.
`define SPP_ASSERT_IMPLY(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("implication violated");

`endif

// File: rtl/spp_pkg.sv
`timescale 1ns / 1ps

package spp_pkg;

    localparam int SCALE_W = 20;
    localparam int PITCH_W = 13;
    localparam int SRC_X_W = 9;
    localparam int SRC_Y_W = 8;
    localparam int COLOR_W = 8;
    localparam int ADDR_W = 24;
    localparam int DST_X_W = 13;
    localparam int DST_Y_W = 12;
    localparam int SPAN_W = 3;
    localparam int SCALE_CAP_INT = 8;

    typedef enum logic [1:0] {
        REG_X_SCALE = 2'd0,
        REG_Y_SCALE = 2'd1,
        REG_LINE_PITCH = 2'd2
    } spp_reg_index_t;

    // One covered rectangle, with spans stored as count minus one.
    typedef struct packed {
        logic [DST_X_W-1:0] x0;
        logic [DST_Y_W-1:0] y0;
        logic [SPAN_W-1:0]  w_m1;
        logic [SPAN_W-1:0]  h_m1;
        logic [COLOR_W-1:0] color;
    } spp_rect_t;

endpackage

// File: rtl/spp_front.sv
`timescale 1ns / 1ps

module spp_front #(
    parameter int FRAC_BITS = 16
) (
    input  logic                         push,
    output logic                         full,
    input  logic [spp_pkg::SRC_X_W-1:0]  src_x,
    input  logic [spp_pkg::SRC_Y_W-1:0]  src_y,
    input  logic [spp_pkg::COLOR_W-1:0]  color,
    input  logic [spp_pkg::SCALE_W-1:0]  x_scale,
    input  logic [spp_pkg::SCALE_W-1:0]  y_scale,
    input  logic                         q_full,
    output logic                         q_push,
    output spp_pkg::spp_rect_t           q_rect
);
    import spp_pkg::*;

    localparam int PROD_W = 30;
    localparam logic [31:0] SCALE_CAP = 32'(SCALE_CAP_INT) << FRAC_BITS;

    logic [SCALE_W-1:0] sx;
    logic [SCALE_W-1:0] sy;
    logic [SRC_X_W:0]   px0;
    logic [SRC_X_W:0]   px1;
    logic [SRC_Y_W:0]   py0;
    logic [SRC_Y_W:0]   py1;
    logic [PROD_W-1:0]  x0_prod;
    logic [PROD_W-1:0]  x1_prod;
    logic [PROD_W-1:0]  y0_prod;
    logic [PROD_W-1:0]  y1_prod;
    logic [PROD_W-1:0]  x0_full;
    logic [PROD_W-1:0]  x1_full;
    logic [PROD_W-1:0]  y0_full;
    logic [PROD_W-1:0]  y1_full;
    logic [DST_X_W-1:0] x0;
    logic [DST_X_W-1:0] x_span;
    logic [DST_Y_W-1:0] y0;
    logic [DST_Y_W-1:0] y_span;

    always_comb
    begin
        sx = ({12'd0, x_scale} > SCALE_CAP) ? SCALE_CAP[SCALE_W-1:0] : x_scale;
        sy = ({12'd0, y_scale} > SCALE_CAP) ? SCALE_CAP[SCALE_W-1:0] : y_scale;
        px0 = {1'b0, src_x};
        px1 = px0 + 1'b1;
        py0 = {1'b0, src_y};
        py1 = py0 + 1'b1;
        x0_prod = PROD_W'(px0) * PROD_W'(sx);
        x1_prod = PROD_W'(px1) * PROD_W'(sx);
        y0_prod = PROD_W'(py0) * PROD_W'(sy);
        y1_prod = PROD_W'(py1) * PROD_W'(sy);
        x0_full = x0_prod >> FRAC_BITS;
        x1_full = x1_prod >> FRAC_BITS;
        y0_full = y0_prod >> FRAC_BITS;
        y1_full = y1_prod >> FRAC_BITS;
        x0 = x0_full[DST_X_W-1:0];
        y0 = y0_full[DST_Y_W-1:0];
        x_span = x1_full[DST_X_W-1:0] - x0;
        y_span = y1_full[DST_Y_W-1:0] - y0;

        q_rect.x0 = x0;
        q_rect.y0 = y0;
        q_rect.w_m1 = SPAN_W'(x_span - 1'b1);
        q_rect.h_m1 = SPAN_W'(y_span - 1'b1);
        q_rect.color = color;

        full = q_full;
        // An empty rectangle is accepted and dropped here.
        q_push = push && !q_full && (x_span != '0) && (y_span != '0);
    end

endmodule

// File: rtl/spp_queue.sv
`timescale 1ns / 1ps

module spp_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  spp_pkg::spp_rect_t push_rect,
    output logic               full,
    input  logic               pop,
    output logic               valid,
    output spp_pkg::spp_rect_t pop_rect
);
    import spp_pkg::*;

    `include "assert_macros.svh"

    spp_rect_t  entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    always_comb
    begin
        full = (count_reg == 2'd2);
        valid = (count_reg != 2'd0);
        pop_rect = entry_reg[rd_ptr_reg];
        do_push = push && !full;
        do_pop = pop && valid;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_rect;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(do_push) - 2'(do_pop);
        end
    end

    `SPP_ASSERT(a_count_bound, clk, rst_n, count_reg <= 2'd2)
    `SPP_ASSERT_IMPLY(a_ptr_match, clk, rst_n, count_reg == 2'd0 || count_reg == 2'd2, wr_ptr_reg == rd_ptr_reg)
    `SPP_ASSERT_IMPLY(a_no_push_full, clk, rst_n, full, !do_push)

endmodule

// File: rtl/spp_back.sv
`timescale 1ns / 1ps

module spp_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_valid,
    input  spp_pkg::spp_rect_t          q_rect,
    output logic                        q_pop,
    input  logic [spp_pkg::PITCH_W-1:0] line_pitch,
    output logic                        empty,
    input  logic                        pop,
    output logic [spp_pkg::ADDR_W-1:0]  pixel_address,
    output logic [spp_pkg::COLOR_W-1:0] pixel_color,
    output logic                        last_write
);
    import spp_pkg::*;

    `include "assert_macros.svh"

    localparam int PROD_W = DST_Y_W + PITCH_W;

    logic               busy_reg, busy_next;
    spp_rect_t          rect_reg, rect_next;
    logic [SPAN_W-1:0]  col_idx_reg, col_idx_next;
    logic [SPAN_W-1:0]  row_idx_reg, row_idx_next;
    logic [DST_X_W-1:0] cur_col_reg, cur_col_next;
    logic [DST_Y_W-1:0] cur_row_reg, cur_row_next;
    logic               out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0]  addr_reg, addr_next;
    logic [COLOR_W-1:0] color_reg, color_next;
    logic               last_reg, last_next;
    logic               taken;
    logic               emit;
    logic               emit_last;
    logic [PROD_W-1:0]  row_prod;

    always_comb
    begin
        taken = pop && out_valid_reg;
        emit = busy_reg && (!out_valid_reg || taken);
        emit_last = emit && (col_idx_reg == rect_reg.w_m1) && (row_idx_reg == rect_reg.h_m1);
        q_pop = q_valid && (!busy_reg || emit_last);
        row_prod = PROD_W'(cur_row_reg) * PROD_W'(line_pitch);

        busy_next = busy_reg;
        rect_next = rect_reg;
        col_idx_next = col_idx_reg;
        row_idx_next = row_idx_reg;
        cur_col_next = cur_col_reg;
        cur_row_next = cur_row_reg;
        out_valid_next = out_valid_reg;
        addr_next = addr_reg;
        color_next = color_reg;
        last_next = last_reg;

        if (emit)
        begin
            out_valid_next = 1'b1;
            addr_next = row_prod[ADDR_W-1:0] + ADDR_W'(cur_col_reg);
            color_next = rect_reg.color;
            last_next = emit_last;
            if (row_idx_reg == rect_reg.h_m1)
            begin
                row_idx_next = '0;
                cur_row_next = rect_reg.y0;
                col_idx_next = col_idx_reg + 1'b1;
                cur_col_next = cur_col_reg + 1'b1;
            end
            else
            begin
                row_idx_next = row_idx_reg + 1'b1;
                cur_row_next = cur_row_reg + 1'b1;
            end
        end
        else if (taken)
        begin
            out_valid_next = 1'b0;
        end

        if (q_pop)
        begin
            busy_next = 1'b1;
            rect_next = q_rect;
            col_idx_next = '0;
            row_idx_next = '0;
            cur_col_next = q_rect.x0;
            cur_row_next = q_rect.y0;
        end
        else if (emit_last)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        rect_reg <= rect_next;
        col_idx_reg <= col_idx_next;
        row_idx_reg <= row_idx_next;
        cur_col_reg <= cur_col_next;
        cur_row_reg <= cur_row_next;
        addr_reg <= addr_next;
        color_reg <= color_next;
        last_reg <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign empty = !out_valid_reg;
    assign pixel_address = addr_reg;
    assign pixel_color = color_reg;
    assign last_write = last_reg;

    `SPP_ASSERT_IMPLY(a_col_bound, clk, rst_n, busy_reg, col_idx_reg <= rect_reg.w_m1)
    `SPP_ASSERT_IMPLY(a_row_bound, clk, rst_n, busy_reg, row_idx_reg <= rect_reg.h_m1)
    `SPP_ASSERT(a_stall_hold, clk, rst_n, (out_valid_reg && !pop) |=> (out_valid_reg && $stable(addr_reg) && $stable(last_reg)))

endmodule

// File: rtl/scaled_pixel_plot_top.sv
`timescale 1ns / 1ps

// Scaled pixel plot: expands one source pixel into frame-buffer writes.
// Input channel: drive src_x, src_y and color with push high; a transaction
// completes on a rising edge with push high and full low.
// Result channel: while empty is low, pixel_address, pixel_color and
// last_write show the oldest write; it completes on an edge with pop high.
// Writes of one pixel come column by column, rows within a column, and the
// final one has last_write set. A pixel with an empty cover yields nothing.
// Configuration: cfg_write with cfg_index and cfg_data, only while idle.
// A rectangle goes through the queue and sequencer to the output registers.
// Throughput: one write per cycle while pop is high; a pixel yields
// width times height writes (1 to 64); back-to-back pixels run gaplessly
// through a two-entry rectangle queue, the write sequencer setting the rate.
// When the receiver stalls the result holds, the queue fills and full rises.
// Reset clears the queue and output and restores scales of 1.0, pitch 320.
module scaled_pixel_plot_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write,
    input  logic [1:0]                  cfg_index,
    input  logic [spp_pkg::SCALE_W-1:0] cfg_data,
    input  logic                        push,
    output logic                        full,
    input  logic [spp_pkg::SRC_X_W-1:0] src_x,
    input  logic [spp_pkg::SRC_Y_W-1:0] src_y,
    input  logic [spp_pkg::COLOR_W-1:0] color,
    output logic                        empty,
    input  logic                        pop,
    output logic [spp_pkg::ADDR_W-1:0]  pixel_address,
    output logic [spp_pkg::COLOR_W-1:0] pixel_color,
    output logic                        last_write
);
    import spp_pkg::*;

    logic [SCALE_W-1:0] x_scale_reg;
    logic [SCALE_W-1:0] y_scale_reg;
    logic [PITCH_W-1:0] pitch_reg;
    logic               q_push;
    logic               q_full;
    logic               q_pop;
    logic               q_valid;
    spp_rect_t          push_rect;
    spp_rect_t          pop_rect;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_scale_reg <= SCALE_W'(65536);
            y_scale_reg <= SCALE_W'(65536);
            pitch_reg <= PITCH_W'(320);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_X_SCALE:    x_scale_reg <= cfg_data;
                REG_Y_SCALE:    y_scale_reg <= cfg_data;
                REG_LINE_PITCH: pitch_reg <= cfg_data[PITCH_W-1:0];
                default:        ;
            endcase
        end
    end

    spp_front #(
        .FRAC_BITS(FRAC_BITS)
    ) u_front (
        .push    (push),
        .full    (full),
        .src_x   (src_x),
        .src_y   (src_y),
        .color   (color),
        .x_scale (x_scale_reg),
        .y_scale (y_scale_reg),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_rect  (push_rect)
    );

    spp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_rect (push_rect),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_rect  (pop_rect)
    );

    spp_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_rect        (pop_rect),
        .q_pop         (q_pop),
        .line_pitch    (pitch_reg),
        .empty         (empty),
        .pop           (pop),
        .pixel_address (pixel_address),
        .pixel_color   (pixel_color),
        .last_write    (last_write)
    );

endmodule

// File: tb/scaled_pixel_plot_checker.sv
`timescale 1ns / 1ps

module scaled_pixel_plot_checker #(
    parameter int FRAC_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write,
    input  logic [1:0]                  cfg_index,
    input  logic [spp_pkg::SCALE_W-1:0] cfg_data,
    input  logic                        push,
    input  logic                        full,
    input  logic [spp_pkg::SRC_X_W-1:0] src_x,
    input  logic [spp_pkg::SRC_Y_W-1:0] src_y,
    input  logic [spp_pkg::COLOR_W-1:0] color,
    input  logic                        empty,
    input  logic                        pop,
    input  logic [spp_pkg::ADDR_W-1:0]  pixel_address,
    input  logic [spp_pkg::COLOR_W-1:0] pixel_color,
    input  logic                        last_write,
    output int                          error_count,
    output int                          writes_pending
);
    import spp_pkg::*;

    typedef struct {
        logic [ADDR_W-1:0]  address;
        logic [COLOR_W-1:0] color;
        logic               last;
    } frame_write_t;

    localparam logic [63:0] SCALE_CAP = 64'(SCALE_CAP_INT) << FRAC_BITS;

    logic [SCALE_W-1:0] x_scale_q;
    logic [SCALE_W-1:0] y_scale_q;
    logic [PITCH_W-1:0] pitch_q;
    frame_write_t       expected_writes[$];

    function automatic logic [63:0] capped_scale(input logic [SCALE_W-1:0] s);
        return (64'(s) > SCALE_CAP) ? SCALE_CAP : 64'(s);
    endfunction

    task automatic expand_pixel(
        input logic [SRC_X_W-1:0] px,
        input logic [SRC_Y_W-1:0] py,
        input logic [COLOR_W-1:0] c
    );
        logic [63:0]  sx;
        logic [63:0]  sy;
        logic [63:0]  x0;
        logic [63:0]  x1;
        logic [63:0]  y0;
        logic [63:0]  y1;
        frame_write_t w;
        sx = capped_scale(x_scale_q);
        sy = capped_scale(y_scale_q);
        x0 = (64'(px) * sx) >> FRAC_BITS;
        x1 = ((64'(px) + 64'd1) * sx) >> FRAC_BITS;
        y0 = (64'(py) * sy) >> FRAC_BITS;
        y1 = ((64'(py) + 64'd1) * sy) >> FRAC_BITS;
        if (x1 <= x0 || y1 <= y0)
            return;
        for (logic [63:0] col = x0; col < x1; col++)
        begin
            for (logic [63:0] row = y0; row < y1; row++)
            begin
                w.address = ADDR_W'(row * 64'(pitch_q) + col);
                w.color   = c;
                w.last    = (col == x1 - 64'd1) && (row == y1 - 64'd1);
                expected_writes.push_back(w);
            end
        end
    endtask

    task automatic check_write();
        frame_write_t w;
        if (expected_writes.size() == 0)
        begin
            $display("%0t: unexpected write transaction, address %h color %h last %b",
                     $time, pixel_address, pixel_color, last_write);
            error_count++;
            return;
        end
        w = expected_writes.pop_front();
        if (pixel_address !== w.address)
        begin
            $display("%0t: pixel_address expected %h actual %h", $time, w.address,
                     pixel_address);
            error_count++;
        end
        if (pixel_color !== w.color)
        begin
            $display("%0t: pixel_color expected %h actual %h", $time, w.color, pixel_color);
            error_count++;
        end
        if (last_write !== w.last)
        begin
            $display("%0t: last_write expected %b actual %b", $time, w.last, last_write);
            error_count++;
        end
    endtask

    initial
    begin
        error_count    = 0;
        writes_pending = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_scale_q = SCALE_W'(65536);
            y_scale_q = SCALE_W'(65536);
            pitch_q   = PITCH_W'(320);
            expected_writes.delete();
        end
        else
        begin
            if (pop && !empty)
                check_write();
            if (push && !full)
                expand_pixel(src_x, src_y, color);
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_X_SCALE:    x_scale_q = cfg_data;
                    REG_Y_SCALE:    y_scale_q = cfg_data;
                    REG_LINE_PITCH: pitch_q = cfg_data[PITCH_W-1:0];
                    default:        ;
                endcase
            end
        end
        writes_pending = expected_writes.size();
    end

endmodule

// File: tb/tb_scaled_pixel_plot_top.sv
`timescale 1ns / 1ps

module tb_scaled_pixel_plot_top;
    import spp_pkg::*;

    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam logic [SCALE_W-1:0] SCALE_ONE = SCALE_W'(65536);
    localparam logic [SCALE_W-1:0] SCALE_MAX = SCALE_W'(524288);

    logic               clk;
    logic               rst_n;
    logic               cfg_write;
    logic [1:0]         cfg_index;
    logic [SCALE_W-1:0] cfg_data;
    logic               push;
    logic               full;
    logic [SRC_X_W-1:0] src_x;
    logic [SRC_Y_W-1:0] src_y;
    logic [COLOR_W-1:0] color;
    logic               empty;
    logic               pop;
    logic [ADDR_W-1:0]  pixel_address;
    logic [COLOR_W-1:0] pixel_color;
    logic               last_write;
    int                 error_count;
    int                 writes_pending;
    bit                 quiet;

    scaled_pixel_plot_top #(
        .FRAC_BITS(16)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .push(push),
        .full(full),
        .src_x(src_x),
        .src_y(src_y),
        .color(color),
        .empty(empty),
        .pop(pop),
        .pixel_address(pixel_address),
        .pixel_color(pixel_color),
        .last_write(last_write)
    );

    scaled_pixel_plot_checker #(
        .FRAC_BITS(16)
    ) checker_i (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .push(push),
        .full(full),
        .src_x(src_x),
        .src_y(src_y),
        .color(color),
        .empty(empty),
        .pop(pop),
        .pixel_address(pixel_address),
        .pixel_color(pixel_color),
        .last_write(last_write),
        .error_count(error_count),
        .writes_pending(writes_pending)
    );

    initial
        clk = 1'b0;

    always #5 clk = ~clk;

    always @(negedge clk)
        pop <= rst_n && (quiet || ($urandom_range(99) >= 21));

    task automatic send_pixel(
        input logic [SRC_X_W-1:0] x,
        input logic [SRC_Y_W-1:0] y,
        input logic [COLOR_W-1:0] c
    );
        @(negedge clk);
        while (!quiet && $urandom_range(99) < 21)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push  <= 1'b1;
        src_x <= x;
        src_y <= y;
        color <= c;
        do
            @(posedge clk);
        while (full);
    endtask

    task automatic settle();
        @(negedge clk);
        push <= 1'b0;
        while (writes_pending != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [SCALE_W-1:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
    endtask

    task automatic apply_setting(
        input logic [SCALE_W-1:0] xs,
        input logic [SCALE_W-1:0] ys,
        input logic [SCALE_W-1:0] pitch_data
    );
        write_reg(REG_X_SCALE, xs);
        write_reg(REG_Y_SCALE, ys);
        write_reg(REG_LINE_PITCH, pitch_data);
        write_reg(REG_UNUSED, SCALE_W'($urandom));
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    function automatic logic [SCALE_W-1:0] pick_scale();
        case ($urandom_range(9))
            0:       return '0;
            1:       return SCALE_W'($urandom_range(1048575, 524289));
            2:       return SCALE_MAX;
            default: return SCALE_W'($urandom_range(262144, 8192));
        endcase
    endfunction

    function automatic logic [SCALE_W-1:0] pick_pitch();
        logic [PITCH_W-1:0] p;
        case ($urandom_range(7))
            0:       p = '0;
            1:       p = PITCH_W'($urandom_range(8191, 4097));
            default: p = PITCH_W'($urandom_range(4096, 1));
        endcase
        return {(SCALE_W-PITCH_W)'($urandom), p};
    endfunction

    initial
    begin
        rst_n     = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        push      = 1'b0;
        src_x     = '0;
        src_y     = '0;
        color     = '0;
        quiet     = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_pixel(9'd0, 8'd0, 8'h00);
        send_pixel(9'd511, 8'd255, 8'hFF);
        send_pixel(9'h155, 8'hAA, 8'h55);
        send_pixel(9'h0AA, 8'h55, 8'hAA);
        settle();

        // Factors above 8.0 saturate; pitch above 4096 is used as written.
        apply_setting(20'hFFFFF, 20'hFFFFF, 20'h01FFF);
        send_pixel(9'd511, 8'd255, 8'hC3);
        send_pixel(9'd0, 8'd0, 8'h01);
        send_pixel(9'd1, 8'd1, 8'h3C);
        settle();

        // A zero factor gives an empty cover, and a zero pitch folds all rows.
        apply_setting('0, 20'h20000, '0);
        send_pixel(9'd5, 8'd5, 8'h07);
        send_pixel(9'd511, 8'd255, 8'h80);
        settle();
        apply_setting(20'h20000, 20'h30000, '0);
        send_pixel(9'd3, 8'd7, 8'h11);
        settle();

        apply_setting(20'h18000, 20'h08000, 20'h00001);
        send_pixel(9'd0, 8'd0, 8'h21);
        send_pixel(9'd1, 8'd1, 8'h42);
        send_pixel(9'd2, 8'd2, 8'h84);
        send_pixel(9'd511, 8'd255, 8'h99);
        settle();

        apply_setting(SCALE_MAX, SCALE_ONE, 20'h01000);
        send_pixel(9'd511, 8'd0, 8'hE7);
        send_pixel(9'd256, 8'd128, 8'h18);
        send_pixel(9'd100, 8'd255, 8'h5A);

        for (int p = 0; p < 5; p++)
        begin
            settle();
            if (p == 0)
                apply_setting(SCALE_W'($urandom_range(196608, 65536)),
                              SCALE_W'($urandom_range(196608, 65536)), pick_pitch());
            else
                apply_setting(pick_scale(), pick_scale(), pick_pitch());
            for (int i = 0; i < 40; i++)
            begin
                quiet = (p == 2);
                send_pixel(SRC_X_W'($urandom_range(511)), SRC_Y_W'($urandom_range(255)),
                           COLOR_W'($urandom_range(255)));
            end
            quiet = 1'b0;
        end
        settle();

        if (error_count == 0)
            $display("tb_scaled_pixel_plot_top: PASS");
        else
            $display("tb_scaled_pixel_plot_top: FAIL");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("tb_scaled_pixel_plot_top: FAIL");
        $finish;
    end

endmodule
